/* hdl/fws_pkg.sv */
// shared constants, types and elaboration-time tables of the fourier waveform synthesizer
package fws_pkg;

  // sizing
  localparam int MAX_HARMONIC    = 63;
  localparam int SINE_TABLE_BITS = 10;
  localparam int PHASE_BITS      = 32;

  // field widths
  localparam int WAVE_W   = 2;
  localparam int AMP_W    = 15;
  localparam int STEP_W   = 32;
  localparam int LIMIT_W  = 6;
  localparam int SAMPLE_W = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  // sine table: quarter wave plus end point, unsigned magnitude of q1.15
  localparam int SINE_ROM_DEPTH = (1 << SINE_TABLE_BITS) + 1;
  localparam int SINE_ADDR_W    = SINE_TABLE_BITS + 1;
  localparam int SINE_W         = 15;

  // odd harmonic bookkeeping
  localparam int NUM_ODD  = (MAX_HARMONIC + 1) / 2;
  localparam int TERM_W   = (NUM_ODD > 1) ? $clog2(NUM_ODD) : 1;
  localparam int CNT_W    = $clog2(NUM_ODD + 1);
  localparam int WEIGHT_W = 17;

  // accumulator and scaling widths
  localparam int PRODUCT_W = WEIGHT_W + SINE_W;
  localparam int ACC_W     = PRODUCT_W + CNT_W + 1;
  localparam int SCALED_W  = ACC_W + AMP_W;
  localparam int ROUND_SH  = 31;
  localparam int ROUNDED_W = SCALED_W - ROUND_SH;

  // fixed-point constants
  localparam logic [63:0] HALF_PI_Q30        = 64'd1686629713;
  localparam logic [63:0] FOUR_OVER_PI_Q32   = 64'd5468522205;
  localparam logic [63:0] EIGHT_OVER_PI2_Q32 = 64'd3481369362;
  localparam logic [WEIGHT_W-1:0] SINE_WEIGHT = WEIGHT_W'(65536);

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_WAVEFORM  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_AMPLITUDE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_STEP      = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LIMIT     = 2'd3;

  // waveform codes
  localparam logic [WAVE_W-1:0] WAVE_SINE     = 2'd0;
  localparam logic [WAVE_W-1:0] WAVE_SQUARE   = 2'd1;
  localparam logic [WAVE_W-1:0] WAVE_TRIANGLE = 2'd2;

  // register reset values
  localparam logic [WAVE_W-1:0]  RST_WAVEFORM  = WAVE_SINE;
  localparam logic [AMP_W-1:0]   RST_AMPLITUDE = 15'd32767;
  localparam logic [STEP_W-1:0]  RST_STEP      = 32'd4294967;
  localparam logic [LIMIT_W-1:0] RST_LIMIT     = 6'd3;

  typedef logic [SINE_W-1:0]   sine_rom_t   [SINE_ROM_DEPTH];
  typedef logic [WEIGHT_W-1:0] weight_rom_t [NUM_ODD];

  // quarter sine entries from a nine term taylor series in q2.30
  function automatic sine_rom_t build_sine_rom();
    sine_rom_t   rom;
    logic [63:0] x;
    logic [63:0] term;
    logic [63:0] sum;
    logic [63:0] v;
    for (int i = 0; i < SINE_ROM_DEPTH; i++) begin
      x    = (HALF_PI_Q30 * 64'(i)) >> SINE_TABLE_BITS;
      term = x;
      sum  = x;
      for (int n = 1; n <= 8; n++) begin
        term = (term * x) >> 30;
        term = (term * x) >> 30;
        term = term / 64'((2 * n) * (2 * n + 1));
        if ((n & 1) == 1) begin
          sum = sum - term;
        end else begin
          sum = sum + term;
        end
      end
      v = (sum * 64'd32767 + (64'd1 << 29)) >> 30;
      if (v > 64'd32767) begin
        v = 64'd32767;
      end
      rom[i] = v[SINE_W-1:0];
    end
    return rom;
  endfunction

  // square series weights 4/(pi*k), q1.16, indexed by (k-1)/2
  function automatic weight_rom_t build_square_weights();
    weight_rom_t rom;
    logic [63:0] w;
    for (int j = 0; j < NUM_ODD; j++) begin
      w      = (FOUR_OVER_PI_Q32 / 64'(2 * j + 1) + 64'd32768) >> 16;
      rom[j] = w[WEIGHT_W-1:0];
    end
    return rom;
  endfunction

  // triangle series weight magnitudes 8/(pi^2*k^2), q1.16
  function automatic weight_rom_t build_triangle_weights();
    weight_rom_t rom;
    logic [63:0] w;
    for (int j = 0; j < NUM_ODD; j++) begin
      w      = (EIGHT_OVER_PI2_Q32 / 64'((2 * j + 1) * (2 * j + 1)) + 64'd32768) >> 16;
      rom[j] = w[WEIGHT_W-1:0];
    end
    return rom;
  endfunction

  localparam weight_rom_t SQUARE_WEIGHTS   = build_square_weights();
  localparam weight_rom_t TRIANGLE_WEIGHTS = build_triangle_weights();

endpackage

/* hdl/fws_sine_rom.sv */
// quarter-wave sine rom with registered read
module fws_sine_rom (
  input  logic                             clk_i,
  input  logic                             en_i,
  input  logic [fws_pkg::SINE_ADDR_W-1:0]  addr_i,
  output logic [fws_pkg::SINE_W-1:0]       data_o
);

  localparam fws_pkg::sine_rom_t ROM = fws_pkg::build_sine_rom();

  logic [fws_pkg::SINE_W-1:0] data_q;

  // synchronous read
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= ROM[addr_i];
    end
  end

  assign data_o = data_q;

endmodule

/* hdl/fourier_waveform_synth_top.sv */
// top level of the additive fourier series waveform synthesizer
// each item runs n harmonic terms, n = 1 for sine and n = (harmonic_limit + 1) / 2
// odd harmonics for square and triangle (n = 0 if harmonic_limit is 0), then scale and done;
// a new item is taken only in idle, after the previous result is loaded; one harmonic per cycle
// on the shared sine rom port and multiply-accumulate
// reset: asynchronous, clears phase, sequencer and output valid, loads register defaults
module fourier_waveform_synth_top (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // configuration write channel
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [fws_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [fws_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  // input item channel
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic                              restart_i,
  // result item channel
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic signed [fws_pkg::SAMPLE_W-1:0] sample_o,
  output logic                              clipped_o
);

  localparam int PB = fws_pkg::PHASE_BITS;
  localparam int TB = fws_pkg::SINE_TABLE_BITS;

  // sequencer codes
  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_RUN   = 2'd1;
  localparam logic [1:0] ST_SCALE = 2'd2;
  localparam logic [1:0] ST_DONE  = 2'd3;

  // configuration registers
  logic [fws_pkg::WAVE_W-1:0]  waveform_q;
  logic [fws_pkg::AMP_W-1:0]   amplitude_q;
  logic [fws_pkg::STEP_W-1:0]  phase_step_q;
  logic [fws_pkg::LIMIT_W-1:0] harmonic_limit_q;

  // control state
  logic [1:0]                state_q, state_d;
  logic [PB-1:0]             phase_q;
  logic [fws_pkg::CNT_W-1:0] issue_cnt_q;
  logic [fws_pkg::CNT_W-1:0] n_terms_q;
  logic                      look_vld_q;
  logic                      out_valid_q;

  // payload registers
  logic [PB-1:0]                  base2_q;
  logic [PB-1:0]                  hp_q;
  logic [fws_pkg::WAVE_W-1:0]     mode_q;
  logic                           neg_q;
  logic [fws_pkg::WEIGHT_W-1:0]   w_q;
  logic signed [fws_pkg::ACC_W-1:0] acc_q;
  logic [fws_pkg::SCALED_W-1:0]   scaled_q;
  logic                           scaled_neg_q;
  logic signed [fws_pkg::SAMPLE_W-1:0] sample_q;
  logic                           clipped_q;

  logic                           in_accept;
  logic                           out_take;
  logic                           out_load;
  logic                           issue;
  logic [PB-1:0]                  phase_eff;
  logic [fws_pkg::LIMIT_W:0]      limit_eff;
  logic [fws_pkg::LIMIT_W:0]      odd_count;
  logic                           series;
  logic [1:0]                     quad;
  logic [TB-1:0]                  idx_raw;
  logic [fws_pkg::SINE_ADDR_W-1:0] rom_addr;
  logic [fws_pkg::SINE_W-1:0]     rom_data;
  logic [fws_pkg::TERM_W-1:0]     term_idx;
  logic [fws_pkg::WEIGHT_W-1:0]   w_sel;
  logic                           wneg_sel;
  logic [fws_pkg::PRODUCT_W-1:0]  product;
  logic signed [fws_pkg::ACC_W-1:0] product_ext;
  logic [fws_pkg::ACC_W-1:0]      mag;
  logic [fws_pkg::SCALED_W-1:0]   rounded_full;
  logic [fws_pkg::ROUNDED_W-1:0]  rounded;
  logic [fws_pkg::SAMPLE_W:0]     sat_mag;
  logic                           clip_d;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_accept   = in_valid_i && !in_stall_o;
  assign out_take    = out_valid_q && !out_stall_i;
  assign out_load    = (state_q == ST_DONE) && (!out_valid_q || !out_stall_i);
  assign issue       = (state_q == ST_RUN) && (issue_cnt_q != n_terms_q);

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      waveform_q       <= fws_pkg::RST_WAVEFORM;
      amplitude_q      <= fws_pkg::RST_AMPLITUDE;
      phase_step_q     <= fws_pkg::RST_STEP;
      harmonic_limit_q <= fws_pkg::RST_LIMIT;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        fws_pkg::REG_WAVEFORM:  waveform_q       <= cfg_data_i[fws_pkg::WAVE_W-1:0];
        fws_pkg::REG_AMPLITUDE: amplitude_q      <= cfg_data_i[fws_pkg::AMP_W-1:0];
        fws_pkg::REG_STEP:      phase_step_q     <= cfg_data_i[fws_pkg::STEP_W-1:0];
        fws_pkg::REG_LIMIT:     harmonic_limit_q <= cfg_data_i[fws_pkg::LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  // start of item: effective phase and number of terms
  always_comb begin
    phase_eff = restart_i ? '0 : phase_q;
    series    = (waveform_q == fws_pkg::WAVE_SQUARE) || (waveform_q == fws_pkg::WAVE_TRIANGLE);
    if (int'(harmonic_limit_q) > fws_pkg::MAX_HARMONIC) begin
      limit_eff = (fws_pkg::LIMIT_W + 1)'(fws_pkg::MAX_HARMONIC);
    end else begin
      limit_eff = {1'b0, harmonic_limit_q};
    end
    odd_count = (limit_eff + 1'b1) >> 1;
  end

  // sine lookup address from harmonic phase
  always_comb begin
    quad    = hp_q[PB-1 -: 2];
    idx_raw = hp_q[PB-3 -: TB];
    if (quad[0]) begin
      rom_addr = fws_pkg::SINE_ADDR_W'(1 << TB) - {1'b0, idx_raw};
    end else begin
      rom_addr = {1'b0, idx_raw};
    end
  end

  fws_sine_rom u_sine_rom (
    .clk_i  (clk_i),
    .en_i   (issue),
    .addr_i (rom_addr),
    .data_o (rom_data)
  );

  // harmonic weight selection
  always_comb begin
    term_idx = issue_cnt_q[fws_pkg::TERM_W-1:0];
    case (mode_q)
      fws_pkg::WAVE_SQUARE: begin
        w_sel    = fws_pkg::SQUARE_WEIGHTS[term_idx];
        wneg_sel = 1'b0;
      end
      fws_pkg::WAVE_TRIANGLE: begin
        w_sel    = fws_pkg::TRIANGLE_WEIGHTS[term_idx];
        wneg_sel = term_idx[0];
      end
      default: begin
        w_sel    = fws_pkg::SINE_WEIGHT;
        wneg_sel = 1'b0;
      end
    endcase
  end

  // shared multiply-accumulate term
  assign product     = fws_pkg::PRODUCT_W'(w_q) * fws_pkg::PRODUCT_W'(rom_data);
  assign product_ext = signed'(fws_pkg::ACC_W'(product));

  // magnitude, rounding and saturation
  always_comb begin
    mag          = acc_q[fws_pkg::ACC_W-1] ? fws_pkg::ACC_W'(-acc_q) : fws_pkg::ACC_W'(acc_q);
    rounded_full = (scaled_q + (fws_pkg::SCALED_W'(1) << (fws_pkg::ROUND_SH - 1)))
                   >> fws_pkg::ROUND_SH;
    rounded      = rounded_full[fws_pkg::ROUNDED_W-1:0];
    clip_d       = 1'b0;
    if (scaled_neg_q) begin
      if (rounded > fws_pkg::ROUNDED_W'(32768)) begin
        sat_mag = (fws_pkg::SAMPLE_W + 1)'(32768);
        clip_d  = 1'b1;
      end else begin
        sat_mag = rounded[fws_pkg::SAMPLE_W:0];
      end
    end else begin
      if (rounded > fws_pkg::ROUNDED_W'(32767)) begin
        sat_mag = (fws_pkg::SAMPLE_W + 1)'(32767);
        clip_d  = 1'b1;
      end else begin
        sat_mag = rounded[fws_pkg::SAMPLE_W:0];
      end
    end
  end

  // sequencer next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          state_d = ST_RUN;
        end
      end
      ST_RUN: begin
        if (!issue && !look_vld_q) begin
          state_d = ST_SCALE;
        end
      end
      ST_SCALE: state_d = ST_DONE;
      ST_DONE: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      phase_q     <= '0;
      issue_cnt_q <= '0;
      n_terms_q   <= '0;
      look_vld_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      look_vld_q <= issue;
      if (in_accept) begin
        phase_q     <= phase_eff + phase_step_q;
        issue_cnt_q <= '0;
        n_terms_q   <= series ? odd_count[fws_pkg::CNT_W-1:0] : fws_pkg::CNT_W'(1);
      end else if (issue) begin
        issue_cnt_q <= issue_cnt_q + 1'b1;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_take) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      hp_q    <= phase_eff;
      base2_q <= {phase_eff[PB-2:0], 1'b0};
      mode_q  <= series ? waveform_q : fws_pkg::WAVE_SINE;
      acc_q   <= '0;
    end else begin
      if (issue) begin
        hp_q  <= hp_q + base2_q;
        w_q   <= w_sel;
        neg_q <= quad[1] ^ wneg_sel;
      end
      if (look_vld_q) begin
        acc_q <= neg_q ? acc_q - product_ext : acc_q + product_ext;
      end
    end
    if (state_q == ST_SCALE) begin
      scaled_q     <= fws_pkg::SCALED_W'(mag) * fws_pkg::SCALED_W'(amplitude_q);
      scaled_neg_q <= acc_q[fws_pkg::ACC_W-1];
    end
    if (out_load) begin
      sample_q  <= scaled_neg_q ? fws_pkg::SAMPLE_W'(-sat_mag) : fws_pkg::SAMPLE_W'(sat_mag);
      clipped_q <= clip_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign sample_o    = sample_q;
  assign clipped_o   = clipped_q;

endmodule

/* hdl/fws_checker.sv */
// port-level checks of the waveform synthesizer and their binding
module fws_checker (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                in_valid_i,
  input logic                                in_stall_o,
  input logic                                out_valid_o,
  input logic                                out_stall_i,
  input logic signed [fws_pkg::SAMPLE_W-1:0] sample_o,
  input logic                                clipped_o
);

  // an accepted item keeps the input stalled through run, scale and done
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o ##1 in_stall_o ##1 in_stall_o)
    else $error("input not stalled while item in progress");

  // a clipped sample sits at one of the range limits
  a_clip_at_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && clipped_o) |->
      (sample_o == 16'sh7FFF) || (sample_o == -16'sh8000))
    else $error("clipped sample not at full scale");

  // a result cannot become valid in the cycle after an item is accepted
  a_no_result_while_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((in_valid_i && !in_stall_o) && !out_valid_o) |=> !out_valid_o)
    else $error("result appeared right after accept");

  // stalled result item holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=>
      out_valid_o && $stable(sample_o) && $stable(clipped_o))
    else $error("stalled result item changed");

endmodule

bind fourier_waveform_synth_top fws_checker u_fws_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .sample_o    (sample_o),
  .clipped_o   (clipped_o)
);
